### design/udpd_pkg.sv
// ----------------------------------------------------------------------------
// udpd_pkg
// Codes, constants and shared types for the UDP port demux table.
// ----------------------------------------------------------------------------
package udpd_pkg;

  localparam logic [1:0] MODE_BIND   = 2'd0;
  localparam logic [1:0] MODE_UNBIND = 2'd1;
  localparam logic [1:0] MODE_RECV   = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_DELIVERED   = 3'd2;
  localparam logic [2:0] ST_NO_LISTENER = 3'd3;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd5;

  localparam logic [15:0] HDR_BYTES = 16'd8;
  localparam logic [15:0] DNS_PORT  = 16'd53;

  // lookup token walking the cell row
  typedef struct packed {
    logic        valid;
    logic        unbind;
    logic [15:0] port;
    logic        hit;
    logic [7:0]  handler;
    logic        free_found;
  } udpd_tok_t;

  // bind write broadcast to the cells
  typedef struct packed {
    logic        we;
    logic [15:0] port;
    logic [7:0]  handler;
  } udpd_wr_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] local_port;
    logic [7:0]  handler_id;
    logic [31:0] source_address;
    logic [15:0] remote_port;
    logic [15:0] length_field;
    logic [15:0] frame_length;
  } udpd_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [7:0]  handler_out;
    logic [31:0] address_out;
    logic [15:0] remote_port_out;
    logic [15:0] payload_length;
    logic        dns_reply;
  } udpd_res_t;

endpackage

### design/udpd_if.sv
// ----------------------------------------------------------------------------
// udpd_if
// Request and result channel interfaces of the UDP port demux table.
// ----------------------------------------------------------------------------
interface udpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] local_port;
  logic [7:0]  handler_id;
  logic [31:0] source_address;
  logic [15:0] remote_port;
  logic [15:0] length_field;
  logic [15:0] frame_length;

  modport source (output valid, mode, local_port, handler_id, source_address,
                  remote_port, length_field, frame_length, input ready);
  modport sink   (input valid, mode, local_port, handler_id, source_address,
                  remote_port, length_field, frame_length, output ready);
endinterface

interface udpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [7:0]  handler_out;
  logic [31:0] address_out;
  logic [15:0] remote_port_out;
  logic [15:0] payload_length;
  logic        dns_reply;

  modport source (output valid, status, slot, handler_out, address_out,
                  remote_port_out, payload_length, dns_reply, input ready);
  modport sink   (input valid, status, slot, handler_out, address_out,
                  remote_port_out, payload_length, dns_reply, output ready);
endinterface

### design/udpd_cell.sv
// ----------------------------------------------------------------------------
// udpd_cell
// One table entry: checks the passing token, clears itself on an unbind of its port and
// takes bind writes addressed to its slot.
// ----------------------------------------------------------------------------
module udpd_cell #(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  udpd_pkg::udpd_tok_t tok_i,
  input  logic [IW-1:0]       hit_idx_i,
  input  logic [IW-1:0]       free_idx_i,
  output udpd_pkg::udpd_tok_t tok_o,
  output logic [IW-1:0]       hit_idx_o,
  output logic [IW-1:0]       free_idx_o,
  input  udpd_pkg::udpd_wr_t  wr_i,
  input  logic [IW-1:0]       wr_idx_i
);
  import udpd_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic        used_r, used_nxt;
  logic [15:0] port_r, port_nxt;
  logic [7:0]  handler_r, handler_nxt;
  udpd_tok_t   tok_r, tok_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic        match;

  assign match = tok_i.valid && used_r && (port_r == tok_i.port);

  always_comb begin
    tok_nxt      = tok_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    used_nxt     = used_r;
    port_nxt     = port_r;
    handler_nxt  = handler_r;
    if (match && !tok_i.hit) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.handler = handler_r;
      hit_idx_nxt     = MY_IDX;
    end
    if (tok_i.valid && !used_r && !tok_i.free_found) begin
      tok_nxt.free_found = 1'b1;
      free_idx_nxt       = MY_IDX;
    end
    if (match && tok_i.unbind) begin
      used_nxt    = 1'b0;
      port_nxt    = '0;
      handler_nxt = '0;
    end
    if (wr_i.we && (wr_idx_i == MY_IDX)) begin
      used_nxt    = 1'b1;
      port_nxt    = wr_i.port;
      handler_nxt = wr_i.handler;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= 1'b0;
      port_r    <= '0;
      handler_r <= '0;
      tok_r     <= '0;
    end else begin
      used_r    <= used_nxt;
      port_r    <= port_nxt;
      handler_r <= handler_nxt;
      tok_r     <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign tok_o      = tok_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;

endmodule

### design/udp_port_demux_table_unit.sv
// ----------------------------------------------------------------------------
// udp_port_demux_table_unit
// Table of listening UDP ports: bind, unbind and datagram header demux.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An accepted request becomes a lookup
// token that walks a row of SOCKETS entry cells, one cell per cycle; each
// cell notes a port match or a free slot, and unbind clears matching cells
// as the token passes. When the token leaves the last cell, a bind is
// written back to the chosen slot and the result is registered; it then
// moves to the output register once that register is empty or being read.
// The next request is taken in the cycle after the result moves to the
// output register, even while that result still waits to be taken. Reset
// empties the table at once.
module udp_port_demux_table_unit #(
  parameter int SOCKETS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  udpd_in_if.sink   in_chan,
  udpd_out_if.source out_chan
);
  import udpd_pkg::*;

  localparam int IW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

  logic      busy_r, busy_nxt;
  udpd_tok_t tok0_r, tok0_nxt;
  udpd_req_t req_r, req_nxt;
  logic      res_valid_r, res_valid_nxt;
  udpd_res_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  udpd_res_t out_r, out_nxt;

  udpd_tok_t     tok_w      [SOCKETS+1];
  logic [IW-1:0] hit_idx_w  [SOCKETS+1];
  logic [IW-1:0] free_idx_w [SOCKETS+1];

  udpd_wr_t      wr;
  logic [IW-1:0] wr_idx;
  udpd_tok_t     tok_end;
  logic          in_acc;
  logic          move;

  assign in_chan.ready = !busy_r;
  assign in_acc        = in_chan.valid && !busy_r;
  assign move          = res_valid_r && (!out_valid_r || out_chan.ready);

  assign tok_w[0]      = tok0_r;
  assign hit_idx_w[0]  = '0;
  assign free_idx_w[0] = '0;
  assign tok_end       = tok_w[SOCKETS];

  for (genvar g = 0; g < SOCKETS; g++) begin : g_cell
    udpd_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_w[g]),
      .hit_idx_i  (hit_idx_w[g]),
      .free_idx_i (free_idx_w[g]),
      .tok_o      (tok_w[g+1]),
      .hit_idx_o  (hit_idx_w[g+1]),
      .free_idx_o (free_idx_w[g+1]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx)
    );
  end

  always_comb begin
    tok0_nxt        = '0;
    tok0_nxt.valid  = in_acc;
    tok0_nxt.unbind = (in_chan.mode == MODE_UNBIND);
    tok0_nxt.port   = in_chan.local_port;

    req_nxt = req_r;
    if (in_acc) begin
      req_nxt.mode           = in_chan.mode;
      req_nxt.local_port     = in_chan.local_port;
      req_nxt.handler_id     = in_chan.handler_id;
      req_nxt.source_address = in_chan.source_address;
      req_nxt.remote_port    = in_chan.remote_port;
      req_nxt.length_field   = in_chan.length_field;
      req_nxt.frame_length   = in_chan.frame_length;
    end
  end

  // result and bind write-back when the token leaves the row
  always_comb begin
    wr         = '0;
    wr.port    = req_r.local_port;
    wr.handler = req_r.handler_id;
    wr_idx     = hit_idx_w[SOCKETS];
    res_nxt    = '0;
    case (req_r.mode)
      MODE_BIND: begin
        if (tok_end.hit) begin
          wr.we        = tok_end.valid;
          res_nxt.slot = 3'(hit_idx_w[SOCKETS]);
        end else if (tok_end.free_found) begin
          wr.we        = tok_end.valid;
          wr_idx       = free_idx_w[SOCKETS];
          res_nxt.slot = 3'(free_idx_w[SOCKETS]);
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      MODE_RECV: begin
        if (req_r.frame_length < HDR_BYTES) begin
          res_nxt.status = ST_TOO_SHORT;
        end else if (req_r.length_field < HDR_BYTES ||
                     req_r.length_field > req_r.frame_length) begin
          res_nxt.status = ST_BAD_LENGTH;
        end else begin
          res_nxt.payload_length = req_r.length_field - HDR_BYTES;
          res_nxt.dns_reply      = (req_r.remote_port == DNS_PORT);
          // a handler of zero means nobody is listening
          if (tok_end.hit && (tok_end.handler != 8'd0)) begin
            res_nxt.status          = ST_DELIVERED;
            res_nxt.slot            = 3'(hit_idx_w[SOCKETS]);
            res_nxt.handler_out     = tok_end.handler;
            res_nxt.address_out     = req_r.source_address;
            res_nxt.remote_port_out = req_r.remote_port;
          end else begin
            res_nxt.status = ST_NO_LISTENER;
          end
        end
      end
      default: begin
        res_nxt.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end

    res_valid_nxt = res_valid_r;
    if (tok_end.valid) begin
      res_valid_nxt = 1'b1;
    end else if (move) begin
      res_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      tok0_r      <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      tok0_r      <= tok0_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    if (tok_end.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_r.status;
  assign out_chan.slot            = out_r.slot;
  assign out_chan.handler_out     = out_r.handler_out;
  assign out_chan.address_out     = out_r.address_out;
  assign out_chan.remote_port_out = out_r.remote_port_out;
  assign out_chan.payload_length  = out_r.payload_length;
  assign out_chan.dns_reply       = out_r.dns_reply;

endmodule
